// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

	// field widths
	localparam int FREQ_W = 27;
	localparam int DUTY_W = 17;
	localparam int CODE_W = 3;
	localparam int CNT_W  = 16;
	localparam int FRAC_W = 16;

	// divider tables, clock divider outer, high-speed divider inner
	localparam int TAB_N   = 8;
	localparam int ENTRY_N = TAB_N * TAB_N;
	localparam int ENTRY_W = 2 * CODE_W;
	localparam int PROD_W  = 11;

	localparam logic [PROD_W-1:0] CLK_DIV [TAB_N] = '{
		11'd1, 11'd2, 11'd4, 11'd8, 11'd16, 11'd32, 11'd64, 11'd128
	};
	localparam logic [PROD_W-1:0] FAST_DIV [TAB_N] = '{
		11'd1, 11'd2, 11'd4, 11'd6, 11'd8, 11'd10, 11'd12, 11'd14
	};

	// base clock and period limits
	localparam int BASE_TICKS    = 100_000_000;
	localparam int PERIOD_MAX    = 65535;
	localparam int DIVISOR_LIMIT = 128 * 14;
	localparam int DIV_SPAN      = DIVISOR_LIMIT * PERIOD_MAX;

	// smallest frequency that some divider product can reach
	localparam int FREQ_MIN = (BASE_TICKS + DIV_SPAN - 1) / DIV_SPAN;

	// product p qualifies when p * f exceeds base ticks over the period limit
	localparam int QUAL_MIN = BASE_TICKS / PERIOD_MAX + 1;
	localparam int QUAL_W   = $clog2(QUAL_MIN + 1);
	localparam int QPROD_W  = PROD_W + QUAL_W;

	// period division: fixed dividend over f times product
	localparam int DIVR_W     = FREQ_W;
	localparam int QUO_W      = CNT_W;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEP;
	localparam logic [FREQ_W-1:0] DIVIDEND = FREQ_W'(BASE_TICKS);
	localparam logic [DIVR_W-1:0] REM_INIT = DIVR_W'(DIVIDEND >> QUO_W);
	localparam logic [QUO_W-1:0]  DIV_LOW  = DIVIDEND[QUO_W-1:0];

	// fallback codes and product
	localparam logic [CODE_W-1:0] CODE_NONE = 3'd7;
	localparam logic [PROD_W-1:0] PROD_NONE = PROD_W'(DIVISOR_LIMIT);

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// side data that travels with an item down the pipeline
	typedef struct packed {
		logic              err;
		logic [CODE_W-1:0] clk_code;
		logic [CODE_W-1:0] fast_code;
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
	} side_t;

	// finished result
	typedef struct packed {
		logic              status;
		logic [CODE_W-1:0] clk_code;
		logic [CODE_W-1:0] fast_code;
		logic [CNT_W-1:0]  period;
		logic [CNT_W-1:0]  cmp_a;
		logic [CNT_W-1:0]  cmp_b;
	} result_t;

	// divider product of one table entry in scan order
	function automatic logic [PROD_W-1:0] entry_prod(int k);
		logic [2*PROD_W-1:0] p;
		p = (2*PROD_W)'(CLK_DIV[k / TAB_N]) * (2*PROD_W)'(FAST_DIV[k % TAB_N]);
		return p[PROD_W-1:0];
	endfunction

	// true when no earlier entry has the same product
	function automatic bit entry_first(int k);
		bit first;
		first = 1'b1;
		for (int m = 0; m < k; m++) begin
			if (entry_prod(m) == entry_prod(k))
				first = 1'b0;
		end
		return first;
	endfunction

	// entry with the next smaller product, -1 when none
	function automatic int entry_pred(int k);
		int best;
		best = -1;
		for (int m = 0; m < ENTRY_N; m++) begin
			if (entry_prod(m) < entry_prod(k) &&
			    (best < 0 || entry_prod(m) > entry_prod(best)))
				best = m;
		end
		return best;
	endfunction

endpackage

// ===== rtl/ppc_req_if.sv =====
interface ppc_req_if import ppc_pkg::*; ;

	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency_hz;
	logic [DUTY_W-1:0] duty_first;
	logic [DUTY_W-1:0] duty_second;

	modport source (
		output valid, frequency_hz, duty_first, duty_second,
		input  ready
	);

	modport sink (
		input  valid, frequency_hz, duty_first, duty_second,
		output ready
	);

endinterface

// ===== rtl/ppc_rsp_if.sv =====
interface ppc_rsp_if import ppc_pkg::*; ;

	logic              valid;
	logic              ready;
	logic              status;
	logic [CODE_W-1:0] clock_div_code;
	logic [CODE_W-1:0] fast_div_code;
	logic [CNT_W-1:0]  period_count;
	logic [CNT_W-1:0]  compare_first;
	logic [CNT_W-1:0]  compare_second;

	modport source (
		output valid, status, clock_div_code, fast_div_code,
		       period_count, compare_first, compare_second,
		input  ready
	);

	modport sink (
		input  valid, status, clock_div_code, fast_div_code,
		       period_count, compare_first, compare_second,
		output ready
	);

endinterface

// ===== rtl/pwm_prescaler_period_calc.sv =====
// channel | dir | payload
// req     | in  | frequency_hz[26:0], duty_first[16:0], duty_second[16:0]
// rsp     | out | status, clock_div_code[2:0], fast_div_code[2:0],
//         |     | period_count[15:0], compare_first[15:0], compare_second[15:0]
//
// one item per cycle while no stall holds the stages; a result passes through
// 3 select stages, 8 division stages at 2 quotient bits each, 2 compare stages and the
// output register; the division stages set the depth
// arst_n clears all valid bits, no clearing pass
// a stalled rsp fills a spare slot, then holds every stage; req.ready is registered

module pwm_prescaler_period_calc import ppc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ppc_req_if.sink   req,
	ppc_rsp_if.source rsp
);

	logic              en;
	logic              sel_vld, div_vld, cmp_vld;
	side_t             sel_side, div_side;
	logic [DIVR_W-1:0] sel_divisor;
	logic [QUO_W-1:0]  div_quo;
	result_t           cmp_res, out_res;

	assign req.ready = en;

	// divider table search and period divisor
	ppc_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (req.valid),
		.freq_i    (req.frequency_hz),
		.duty_a_i  (req.duty_first),
		.duty_b_i  (req.duty_second),
		.vld_o     (sel_vld),
		.side_o    (sel_side),
		.divisor_o (sel_divisor)
	);

	// period as base ticks over divisor
	ppc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (sel_vld),
		.divisor_i (sel_divisor),
		.side_i    (sel_side),
		.vld_o     (div_vld),
		.quo_o     (div_quo),
		.side_o    (div_side)
	);

	// compare values and error override
	ppc_compare u_compare (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (div_vld),
		.quo_i  (div_quo),
		.side_i (div_side),
		.vld_o  (cmp_vld),
		.res_o  (cmp_res)
	);

	// output register with spare slot
	ppc_skid u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (cmp_vld),
		.s_ready (en),
		.s_res   (cmp_res),
		.m_valid (rsp.valid),
		.m_ready (rsp.ready),
		.m_res   (out_res)
	);

	assign rsp.status         = out_res.status;
	assign rsp.clock_div_code = out_res.clk_code;
	assign rsp.fast_div_code  = out_res.fast_code;
	assign rsp.period_count   = out_res.period;
	assign rsp.compare_first  = out_res.cmp_a;
	assign rsp.compare_second = out_res.cmp_b;

endmodule

// ===== rtl/ppc_select.sv =====
module ppc_select import ppc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [FREQ_W-1:0] freq_i,
	input  logic [DUTY_W-1:0] duty_a_i,
	input  logic [DUTY_W-1:0] duty_b_i,
	output logic              vld_o,
	output side_t             side_o,
	output logic [DIVR_W-1:0] divisor_o
);

	logic [QUAL_W-1:0]  freq_sat;
	logic [ENTRY_N-1:0] qual_d;
	logic [ENTRY_N-1:0] win;
	logic [ENTRY_W-1:0] code_d;
	logic [PROD_W-1:0]  best_d;
	logic [FREQ_W+PROD_W-1:0] dprod;

	logic               vld_s1, vld_s2, vld_s3;
	logic [ENTRY_N-1:0] qual_s1;
	logic [FREQ_W-1:0]  freq_s1, freq_s2;
	logic [DUTY_W-1:0]  duty_a_s1, duty_b_s1, duty_a_s2, duty_b_s2;
	logic               err_s1, err_s2;
	logic [ENTRY_W-1:0] code_s2;
	logic [PROD_W-1:0]  best_s2;
	side_t              side_s3;
	logic [DIVR_W-1:0]  divisor_s3;

	// frequency clipped to the qualifying threshold, larger values all qualify
	assign freq_sat = (freq_i >= FREQ_W'(QUAL_MIN)) ? QUAL_W'(QUAL_MIN)
	                                                : freq_i[QUAL_W-1:0];

	// one constant-product compare per table entry
	for (genvar k = 0; k < ENTRY_N; k++) begin : g_qual
		localparam logic [PROD_W-1:0] PK = entry_prod(k);
		assign qual_d[k] = (QPROD_W'(PK) * QPROD_W'(freq_sat)) >= QPROD_W'(QUAL_MIN);
	end

	// qualifying is monotonic in the product: the winner is the first entry of the
	// smallest qualifying product, i.e. the next smaller product fails
	for (genvar k = 0; k < ENTRY_N; k++) begin : g_win
		localparam int PRED  = entry_pred(k);
		localparam bit FIRST = entry_first(k);
		if (PRED < 0) begin : g_base
			assign win[k] = qual_s1[k] & FIRST;
		end else begin : g_rest
			assign win[k] = qual_s1[k] & FIRST & ~qual_s1[PRED];
		end
	end

	// one-hot winner to entry index and product
	always_comb begin
		code_d = '0;
		best_d = '0;
		for (int k = 0; k < ENTRY_N; k++) begin
			if (win[k]) begin
				code_d = code_d | ENTRY_W'(k);
				best_d = best_d | entry_prod(k);
			end
		end
		if (!(|win)) begin
			code_d = {CODE_NONE, CODE_NONE};
			best_d = PROD_NONE;
		end
	end

	// period divisor, fits the frequency width whenever there is no error
	assign dprod = (FREQ_W+PROD_W)'(freq_s2) * (FREQ_W+PROD_W)'(best_s2);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			qual_s1   <= qual_d;
			freq_s1   <= freq_i;
			duty_a_s1 <= duty_a_i;
			duty_b_s1 <= duty_b_i;
			err_s1    <= freq_i < FREQ_W'(FREQ_MIN);

			code_s2   <= code_d;
			best_s2   <= best_d;
			freq_s2   <= freq_s1;
			duty_a_s2 <= duty_a_s1;
			duty_b_s2 <= duty_b_s1;
			err_s2    <= err_s1;

			side_s3.err       <= err_s2;
			side_s3.clk_code  <= code_s2[ENTRY_W-1:CODE_W];
			side_s3.fast_code <= code_s2[CODE_W-1:0];
			side_s3.duty_a    <= duty_a_s2;
			side_s3.duty_b    <= duty_b_s2;
			divisor_s3        <= dprod[DIVR_W-1:0];
		end
	end

	assign vld_o     = vld_s3;
	assign side_o    = side_s3;
	assign divisor_o = divisor_s3;

endmodule

// ===== rtl/ppc_divider.sv =====
module ppc_divider import ppc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [DIVR_W-1:0] divisor_i,
	input  side_t             side_i,
	output logic              vld_o,
	output logic [QUO_W-1:0]  quo_o,
	output side_t             side_o
);

	logic              vld_s  [DIV_STAGES];
	logic [DIVR_W-1:0] rem_s  [DIV_STAGES];
	logic [DIVR_W-1:0] dvs_s  [DIV_STAGES];
	logic [QUO_W-1:0]  quo_s  [DIV_STAGES];
	side_t             side_s [DIV_STAGES];

	// restoring division, a fixed number of quotient bits per stage
	for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
		logic              vld_in;
		logic [DIVR_W-1:0] rem_in;
		logic [DIVR_W-1:0] dvs_in;
		logic [QUO_W-1:0]  quo_in;
		side_t             side_in;
		logic [DIVR_W-1:0] rem_d;
		logic [QUO_W-1:0]  quo_d;

		if (st == 0) begin : g_head
			assign vld_in  = vld_i;
			assign rem_in  = REM_INIT;
			assign dvs_in  = divisor_i;
			assign quo_in  = '0;
			assign side_in = side_i;
		end else begin : g_link
			assign vld_in  = vld_s[st-1];
			assign rem_in  = rem_s[st-1];
			assign dvs_in  = dvs_s[st-1];
			assign quo_in  = quo_s[st-1];
			assign side_in = side_s[st-1];
		end

		// shift in the next dividend bit, subtract when it fits
		always_comb begin
			logic [DIVR_W:0] trial;
			logic            qbit;
			rem_d = rem_in;
			quo_d = quo_in;
			for (int b = 0; b < DIV_STEP; b++) begin
				trial = {rem_d, DIV_LOW[QUO_W-1-(st*DIV_STEP+b)]};
				qbit  = trial >= {1'b0, dvs_in};
				if (qbit)
					trial = trial - {1'b0, dvs_in};
				rem_d = trial[DIVR_W-1:0];
				quo_d = {quo_d[QUO_W-2:0], qbit};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[st] <= 1'b0;
			else if (en)
				vld_s[st] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st]  <= rem_d;
				dvs_s[st]  <= dvs_in;
				quo_s[st]  <= quo_d;
				side_s[st] <= side_in;
			end
		end
	end

	assign vld_o  = vld_s[DIV_STAGES-1];
	assign quo_o  = quo_s[DIV_STAGES-1];
	assign side_o = side_s[DIV_STAGES-1];

endmodule

// ===== rtl/ppc_compare.sv =====
module ppc_compare import ppc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [QUO_W-1:0] quo_i,
	input  side_t            side_i,
	output logic             vld_o,
	output result_t          res_o
);

	localparam int MUL_W = CNT_W + DUTY_W;
	localparam int RAW_W = MUL_W - FRAC_W;

	logic [CNT_W-1:0] period;
	logic [MUL_W-1:0] mul_a, mul_b;
	logic [RAW_W-1:0] raw_a, raw_b;
	logic [CNT_W-1:0] sat_a, sat_b;
	result_t          res_d;

	logic             vld_s1, vld_s2;
	logic [MUL_W-1:0] mul_a_s1, mul_b_s1;
	logic [CNT_W-1:0] period_s1;
	side_t            side_s1;
	result_t          res_s2;

	function automatic logic [MUL_W-1:0] duty_ext(logic [DUTY_W-1:0] d);
		return MUL_W'(d);
	endfunction

	// quotient already lies within the period range
	assign period = quo_i[CNT_W-1:0];
	assign mul_a  = MUL_W'(period) * duty_ext(side_i.duty_a);
	assign mul_b  = MUL_W'(period) * duty_ext(side_i.duty_b);

	// drop the fraction and saturate at the period limit
	assign raw_a = mul_a_s1[MUL_W-1:FRAC_W];
	assign raw_b = mul_b_s1[MUL_W-1:FRAC_W];
	assign sat_a = (|raw_a[RAW_W-1:CNT_W]) ? '1 : raw_a[CNT_W-1:0];
	assign sat_b = (|raw_b[RAW_W-1:CNT_W]) ? '1 : raw_b[CNT_W-1:0];

	// error items give the fixed out-of-range answer
	always_comb begin
		if (side_s1.err) begin
			res_d.status    = STATUS_RANGE;
			res_d.clk_code  = CODE_NONE;
			res_d.fast_code = CODE_NONE;
			res_d.period    = '0;
			res_d.cmp_a     = '0;
			res_d.cmp_b     = '0;
		end else begin
			res_d.status    = STATUS_OK;
			res_d.clk_code  = side_s1.clk_code;
			res_d.fast_code = side_s1.fast_code;
			res_d.period    = period_s1;
			res_d.cmp_a     = sat_a;
			res_d.cmp_b     = sat_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_a_s1  <= mul_a;
			mul_b_s1  <= mul_b;
			period_s1 <= period;
			side_s1   <= side_i;
			res_s2    <= res_d;
		end
	end

	assign vld_o = vld_s2;
	assign res_o = res_s2;

endmodule

// ===== rtl/ppc_skid.sv =====
module ppc_skid import ppc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_valid,
	output logic    s_ready,
	input  result_t s_res,
	output logic    m_valid,
	input  logic    m_ready,
	output result_t m_res
);

	logic    main_vld_q, skid_vld_q;
	result_t main_q, skid_q;

	// pipeline may move whenever the spare slot is empty
	assign s_ready = !skid_vld_q;
	assign m_valid = main_vld_q;
	assign m_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || m_ready) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= s_valid;
			end
		end else if (s_valid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	// output register refills from the spare slot first
	always_ff @(posedge clk) begin
		if (!main_vld_q || m_ready) begin
			if (skid_vld_q)
				main_q <= skid_q;
			else if (s_valid)
				main_q <= s_res;
		end else if (s_valid && !skid_vld_q) begin
			skid_q <= s_res;
		end
	end

endmodule

// ===== test/pwm_prescaler_period_calc_tb.sv =====
`timescale 1ns / 1ps

module pwm_prescaler_period_calc_tb;
	import ppc_pkg::*;

	// own copy of the arithmetic limits
	localparam longint unsigned HZ_BASE    = 64'd100_000_000;
	localparam longint unsigned CNT_TOP    = 64'd65535;
	localparam longint unsigned PROD_TOP   = 64'd1792;
	localparam int              CYCLE_LIMIT = 400_000;
	localparam int              HOLD_CYCLES = 400;
	localparam int              DRAIN_CYCLES = 40;
	localparam int              PRINT_CAP   = 60;

	typedef struct {
		logic [FREQ_W-1:0] freq;
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
	} freq_request_t;

	logic clk;
	logic arst_n;

	ppc_req_if req_ch ();
	ppc_rsp_if rsp_ch ();

	pwm_prescaler_period_calc u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	freq_request_t freq_requests[$];
	result_t       due_settings[$];
	freq_request_t next_req;
	result_t       got_setting;
	result_t       want_setting;

	int  pushed_n;
	int  accepted_n;
	int  mismatch_n;
	int  cycle_n;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_req_n;
	int  hold_seen_n;
	int  hold_left;
	bit  req_taken;
	bit  ready_next;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// divider tables: powers of two, and 1 followed by even steps
	function automatic longint unsigned clk_div_of(int idx);
		return 64'd1 << idx;
	endfunction

	function automatic longint unsigned fast_div_of(int idx);
		return (idx == 0) ? 64'd1 : 64'd2 * idx;
	endfunction

	// compare value, saturating at the period limit
	function automatic logic [CNT_W-1:0] duty_compare(longint unsigned per,
							  logic [DUTY_W-1:0] duty);
		longint unsigned c;
		c = (per * duty) >> 16;
		if (c > CNT_TOP)
			c = CNT_TOP;
		return c[CNT_W-1:0];
	endfunction

	// smallest qualifying divider product, period and compare values
	function automatic result_t predict_setting(logic [FREQ_W-1:0] freq,
						    logic [DUTY_W-1:0] da,
						    logic [DUTY_W-1:0] db);
		result_t         r;
		longint unsigned f;
		longint unsigned p;
		longint unsigned best;
		longint unsigned per;
		int              ci;
		int              fi;
		f    = freq;
		best = 0;
		ci   = 7;
		fi   = 7;
		if (f == 0 || HZ_BASE > PROD_TOP * CNT_TOP * f) begin
			r.status    = STATUS_RANGE;
			r.clk_code  = CODE_NONE;
			r.fast_code = CODE_NONE;
			r.period    = '0;
			r.cmp_a     = '0;
			r.cmp_b     = '0;
			return r;
		end
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++) begin
				p = clk_div_of(i) * fast_div_of(j);
				if (p * f * CNT_TOP > HZ_BASE && (best == 0 || p < best)) begin
					best = p;
					ci   = i;
					fi   = j;
				end
			end
		end
		if (best == 0)
			best = PROD_TOP;
		per = HZ_BASE / (f * best);
		if (per > CNT_TOP)
			per = CNT_TOP;
		r.status    = STATUS_OK;
		r.clk_code  = ci[CODE_W-1:0];
		r.fast_code = fi[CODE_W-1:0];
		r.period    = per[CNT_W-1:0];
		r.cmp_a     = duty_compare(per, da);
		r.cmp_b     = duty_compare(per, db);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		if (mismatch_n < PRINT_CAP)
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		mismatch_n++;
	endtask

	task automatic add_request(longint unsigned f, longint unsigned da, longint unsigned db);
		freq_request_t r;
		r.freq   = f[FREQ_W-1:0];
		r.duty_a = da[DUTY_W-1:0];
		r.duty_b = db[DUTY_W-1:0];
		freq_requests.push_back(r);
		pushed_n++;
	endtask

	// frequency spread: zero and small values, boundaries of the product table, log scale, full width
	function automatic longint unsigned rand_freq();
		longint unsigned p;
		longint unsigned f0;
		int              k;
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 60) == 0 ? 0 : $urandom_range(1, 4000);
			1, 2: begin
				p  = clk_div_of($urandom_range(0, 7)) * fast_div_of($urandom_range(0, 7));
				f0 = HZ_BASE / (p * CNT_TOP) + 1;
				f0 = f0 + $urandom_range(0, 2);
				return (f0 > 1) ? f0 - 1 : 1;
			end
			3: return $urandom & ((1 << FREQ_W) - 1);
			default: begin
				k = $urandom_range(1, FREQ_W);
				return ($urandom & ((1 << k) - 1)) | (1 << (k - 1));
			end
		endcase
	endfunction

	function automatic longint unsigned rand_duty();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65536;
			2: return $urandom & ((1 << DUTY_W) - 1);
			3: return 65535;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			add_request(rand_freq(), rand_duty(), rand_duty());
	endtask

	// request driver, changes on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (freq_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_req            = freq_requests.pop_front();
				req_ch.valid        <= 1'b1;
				req_ch.frequency_hz <= next_req.freq;
				req_ch.duty_first   <= next_req.duty_a;
				req_ch.duty_second  <= next_req.duty_b;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver, random stalls plus the long hold-off
	always @(negedge clk) begin
		if (hold_seen_n != hold_req_n) begin
			hold_seen_n = hold_req_n;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			ready_next = 1'b0;
		end else begin
			ready_next = ($urandom_range(0, 99) >= recv_idle_pct);
		end
		rsp_ch.ready <= ready_next;
	end

	// monitor: check results, predict from accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_setting.status    = rsp_ch.status;
				got_setting.clk_code  = rsp_ch.clock_div_code;
				got_setting.fast_code = rsp_ch.fast_div_code;
				got_setting.period    = rsp_ch.period_count;
				got_setting.cmp_a     = rsp_ch.compare_first;
				got_setting.cmp_b     = rsp_ch.compare_second;
				if (due_settings.size() == 0) begin
					report_mismatch("result transfer with none pending",
							got_setting.period, 0);
				end else begin
					want_setting = due_settings.pop_front();
					if (got_setting.status !== want_setting.status)
						report_mismatch("status", got_setting.status, want_setting.status);
					if (got_setting.clk_code !== want_setting.clk_code)
						report_mismatch("clock_div_code", got_setting.clk_code,
								want_setting.clk_code);
					if (got_setting.fast_code !== want_setting.fast_code)
						report_mismatch("fast_div_code", got_setting.fast_code,
								want_setting.fast_code);
					if (got_setting.period !== want_setting.period)
						report_mismatch("period_count", got_setting.period,
								want_setting.period);
					if (got_setting.cmp_a !== want_setting.cmp_a)
						report_mismatch("compare_first", got_setting.cmp_a,
								want_setting.cmp_a);
					if (got_setting.cmp_b !== want_setting.cmp_b)
						report_mismatch("compare_second", got_setting.cmp_b,
								want_setting.cmp_b);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				due_settings.push_back(predict_setting(req_ch.frequency_hz,
								       req_ch.duty_first,
								       req_ch.duty_second));
				accepted_n++;
			end
		end
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
	end

	// run limit
	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("[pwm_prescaler_period_calc] ERROR");
			$finish;
		end
	end

	// sequence of phases
	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.frequency_hz = '0;
		req_ch.duty_first   = '0;
		req_ch.duty_second  = '0;
		rsp_ch.ready        = 1'b0;
		req_taken           = 1'b0;
		pushed_n            = 0;
		accepted_n          = 0;
		mismatch_n          = 0;
		cycle_n             = 0;
		hold_req_n          = 0;
		hold_seen_n         = 0;
		hold_left           = 0;
		send_idle_pct       = 9;
		recv_idle_pct       = 57;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero frequency, table ends, ties, 100 MHz edge, duty extremes
		add_request(0, 0, 0);
		add_request(0, 65536, 131071);
		add_request(1, 65536, 0);
		add_request(1, 131071, 65535);
		add_request(2, 32768, 65536);
		add_request(3, 1, 131071);
		add_request(10, 65536, 65536);
		add_request(100, 16384, 49152);
		add_request(200, 65535, 1);
		add_request(250, 65536, 0);
		add_request(300, 32768, 32768);
		add_request(500, 131071, 0);
		add_request(1000, 65536, 65535);
		add_request(1525, 65536, 65536);
		add_request(1526, 65536, 65536);
		add_request(50000, 43690, 21845);
		add_request(99999999, 65536, 131071);
		add_request(100000000, 65536, 131071);
		add_request(100000001, 65536, 65536);
		add_request((1 << FREQ_W) - 1, 131071, 131071);
		add_request(89478485, 87381, 43690);

		// sender mostly busy, receiver stalls often
		add_random(600);
		wait (accepted_n == pushed_n);

		// sender gaps often, receiver mostly ready
		@(posedge clk);
		send_idle_pct = 57;
		recv_idle_pct = 9;
		add_random(600);
		wait (accepted_n == pushed_n);

		// no idling, with one long receiver hold-off to back up the pipeline
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(600);
		hold_req_n++;
		wait (accepted_n == pushed_n && due_settings.size() == 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_settings.size() != 0)
			report_mismatch("results never delivered", 0, due_settings.size());
		if (mismatch_n == 0) begin
			$display("[pwm_prescaler_period_calc] OK");
		end else begin
			$display("[pwm_prescaler_period_calc] ERROR");
		end
		$finish;
	end

endmodule
